// ===== hdl/per_cpu_starvation_watchdog_assert.svh =====
// ----------------------------------------------------------------------------
// Starvation watchdog assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PER_CPU_STARVATION_WATCHDOG_ASSERT_SVH
`define PER_CPU_STARVATION_WATCHDOG_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCSW_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCSW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/pcsw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Starvation watchdog package
// Widths, codes, shared types and the wrap-aware time compare.
// ----------------------------------------------------------------------------
package pcsw_pkg;

	localparam int SLOT_W         = 3;
	localparam int NUM_SLOTS      = 1 << SLOT_W;
	localparam int TIME_W         = 32;
	localparam int THR_W          = 16;
	localparam int TALLY_W        = 2;
	localparam int ALERT_MAX      = 3;
	localparam int WINDOW_SECONDS = 60;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;
	localparam int S_DATA_W       = 40;
	localparam int M_DATA_W       = 40;
	localparam int REQ_W          = 2;
	localparam int VERDICT_W      = 2;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(10);

	typedef enum logic [REQ_W-1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_TOUCH  = 2'd1,
		REQ_START  = 2'd2
	} req_t;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_HEALTHY = 2'd0,
		VERDICT_ALERT   = 2'd1,
		VERDICT_LIMIT   = 2'd2
	} verdict_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE    = 2'd0,
		CFG_CPU_MASK  = 2'd1,
		CFG_THRESHOLD = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic                 enable;
		logic [NUM_SLOTS-1:0] cpu_mask;
		logic [THR_W-1:0]     threshold;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]  touch_time;
		logic [TALLY_W-1:0] alert_tally;
		logic [TIME_W-1:0]  window_begin;
	} slot_entry_t;

	typedef struct packed {
		logic              touch_we;
		logic              tally_we;
		logic              window_we;
		logic [SLOT_W-1:0] slot;
		slot_entry_t       data;
	} slot_upd_t;

	typedef struct packed {
		logic              has_result;
		logic [SLOT_W-1:0] slot;
		verdict_t          verdict;
		logic [TIME_W-1:0] stuck;
	} result_t;

	// True when a is strictly after b, modulo 2^32.
	function automatic logic later_than(input logic [TIME_W-1:0] a,
	                                    input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = b - a;
		return d[TIME_W-1];
	endfunction

endpackage

// ===== hdl/per_cpu_starvation_watchdog.sv =====
`timescale 1ns / 1ps
// The watchdog takes one event word per clock cycle unless the event in the
// evaluation stage has a verdict and a waiting verdict word is not taken. An
// enabled and monitored sample yields a verdict word that passes through the
// input register and then the output register, where it is presented; touch,
// start, unused request types and unmonitored samples give no word. The slot
// table read-modify-write completes as the event advances out of the evaluation stage, so back-to-back events on the
// same slot see each other's updates. An output register holds a waiting verdict
// while the next event is taken in. Configuration is to be changed only while no
// event is in flight; the user is bound to this, the block does not enforce it.
// ----------------------------------------------------------------------------
// Per-CPU starvation watchdog
// Input register, slot table evaluation and output register around it.
// ----------------------------------------------------------------------------
module per_cpu_starvation_watchdog (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pcsw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pcsw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// cpu_index [2:0], now_seconds [34:3], zero fill above
	input  logic [pcsw_pkg::S_DATA_W-1:0]    s_tdata,
	// req_type [1:0]
	input  logic [pcsw_pkg::REQ_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// slot_out [2:0], stuck_seconds [34:3], zero fill above
	output logic [pcsw_pkg::M_DATA_W-1:0]    m_tdata,
	// verdict [1:0]
	output logic [pcsw_pkg::VERDICT_W-1:0]   m_tuser
);
	import pcsw_pkg::*;

	cfg_t              cfg;
	slot_entry_t       entry;
	slot_upd_t         upd;
	result_t           res;

	logic              valid_s1;
	req_t              kind_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [TIME_W-1:0] now_s1;

	logic              valid_s2;
	logic [SLOT_W-1:0] slot_s2;
	verdict_t          verdict_s2;
	logic [TIME_W-1:0] stuck_s2;

	logic              advance;

	assign advance  = valid_s1 && (!res.has_result || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= req_t'(s_tuser);
			slot_s1 <= s_tdata[SLOT_W-1:0];
			now_s1  <= s_tdata[SLOT_W+TIME_W-1:SLOT_W];
		end
	end

	pcsw_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pcsw_slot_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_slot  (slot_s1),
		.rd_entry (entry),
		.upd      (upd)
	);

	pcsw_eval u_eval (
		.go    (advance),
		.cfg   (cfg),
		.kind  (kind_s1),
		.slot  (slot_s1),
		.now   (now_s1),
		.entry (entry),
		.upd   (upd),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res.has_result) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.has_result) begin
			slot_s2    <= res.slot;
			verdict_s2 <= res.verdict;
			stuck_s2   <= res.stuck;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(M_DATA_W - TIME_W - SLOT_W){1'b0}}, stuck_s2, slot_s2};
	assign m_tuser  = verdict_s2;

`include "per_cpu_starvation_watchdog_assert.svh"

	`PCSW_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(now_s1), "stalled event word lost or changed")
	`PCSW_ASSERT_NEXT(a_out_load, advance && res.has_result, m_tvalid && m_tdata[2:0] == $past(slot_s1), "verdict word not loaded")
	`PCSW_ASSERT_NEXT(a_out_drain, m_tvalid && m_tready && !(advance && res.has_result), !m_tvalid, "taken verdict word repeated")
	`PCSW_ASSERT_SAME(a_healthy_zero, m_tvalid && m_tuser == VERDICT_HEALTHY, m_tdata[34:3] == '0, "healthy verdict with nonzero stuck time")
	`PCSW_ASSERT_SAME(a_no_write_stall, !advance, !upd.touch_we && !upd.tally_we && !upd.window_we, "slot table written without advance")

endmodule

// ===== hdl/pcsw_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Starvation watchdog configuration registers
// Holds enable, slot mask and threshold, written through a plain write port.
// ----------------------------------------------------------------------------
module pcsw_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pcsw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcsw_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output pcsw_pkg::cfg_t                 cfg
);
	import pcsw_pkg::*;

	logic                 enable_q;
	logic [NUM_SLOTS-1:0] cpu_mask_q;
	logic [THR_W-1:0]     threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b1;
			cpu_mask_q  <= '1;
			threshold_q <= THR_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENABLE:    enable_q    <= cfg_wdata[0];
				CFG_CPU_MASK:  cpu_mask_q  <= cfg_wdata[NUM_SLOTS-1:0];
				CFG_THRESHOLD: threshold_q <= cfg_wdata[THR_W-1:0];
				default:       ;
			endcase
		end
	end

	assign cfg.enable    = enable_q;
	assign cfg.cpu_mask  = cpu_mask_q;
	assign cfg.threshold = threshold_q;

endmodule

// ===== hdl/pcsw_slot_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Starvation watchdog slot table
// Per-slot touch time, alert tally and window start, one read and one update.
// ----------------------------------------------------------------------------
module pcsw_slot_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [pcsw_pkg::SLOT_W-1:0] rd_slot,
	output pcsw_pkg::slot_entry_t       rd_entry,
	input  pcsw_pkg::slot_upd_t         upd
);
	import pcsw_pkg::*;

	logic [TIME_W-1:0]  touch_time_q   [NUM_SLOTS];
	logic [TALLY_W-1:0] alert_tally_q  [NUM_SLOTS];
	logic [TIME_W-1:0]  window_begin_q [NUM_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				touch_time_q[i]   <= '0;
				alert_tally_q[i]  <= '0;
				window_begin_q[i] <= '0;
			end
		end else begin
			if (upd.touch_we) begin
				touch_time_q[upd.slot] <= upd.data.touch_time;
			end
			if (upd.tally_we) begin
				alert_tally_q[upd.slot] <= upd.data.alert_tally;
			end
			if (upd.window_we) begin
				window_begin_q[upd.slot] <= upd.data.window_begin;
			end
		end
	end

	assign rd_entry.touch_time   = touch_time_q[rd_slot];
	assign rd_entry.alert_tally  = alert_tally_q[rd_slot];
	assign rd_entry.window_begin = window_begin_q[rd_slot];

endmodule

// ===== hdl/pcsw_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Starvation watchdog event evaluation
// Decides the slot update and the verdict for one registered event word.
// ----------------------------------------------------------------------------
module pcsw_eval (
	input  logic                        go,
	input  pcsw_pkg::cfg_t              cfg,
	input  pcsw_pkg::req_t              kind,
	input  logic [pcsw_pkg::SLOT_W-1:0] slot,
	input  logic [pcsw_pkg::TIME_W-1:0] now,
	input  pcsw_pkg::slot_entry_t       entry,
	output pcsw_pkg::slot_upd_t         upd,
	output pcsw_pkg::result_t           res
);
	import pcsw_pkg::*;

	logic               win_expired;
	logic               starved;
	logic [TALLY_W-1:0] tally_w;
	logic [TIME_W-1:0]  window_w;
	logic [TIME_W-1:0]  stuck_w;

	always_comb begin
		win_expired = later_than(now, entry.window_begin + TIME_W'(WINDOW_SECONDS));
		tally_w     = win_expired ? '0 : entry.alert_tally;
		window_w    = win_expired ? now : entry.window_begin;
		starved     = later_than(now, entry.touch_time + TIME_W'(cfg.threshold));
		stuck_w     = now - entry.touch_time;

		upd            = '0;
		upd.slot       = slot;
		upd.data       = entry;
		res            = '0;
		res.slot       = slot;
		res.verdict    = VERDICT_HEALTHY;

		case (kind)
			REQ_START: begin
				upd.touch_we          = go;
				upd.window_we         = go;
				upd.data.touch_time   = now;
				upd.data.window_begin = now;
			end
			REQ_TOUCH: begin
				upd.touch_we        = go;
				upd.data.touch_time = now;
			end
			REQ_SAMPLE: begin
				if (cfg.enable && cfg.cpu_mask[slot]) begin
					res.has_result        = 1'b1;
					upd.tally_we          = go;
					upd.window_we         = go;
					upd.data.alert_tally  = tally_w;
					upd.data.window_begin = window_w;
					if (starved) begin
						upd.touch_we        = go;
						upd.data.touch_time = now;
						res.stuck           = stuck_w;
						if (tally_w >= TALLY_W'(ALERT_MAX)) begin
							res.verdict = VERDICT_LIMIT;
						end else begin
							res.verdict          = VERDICT_ALERT;
							upd.data.alert_tally = tally_w + 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

endmodule
